>>> rtl/integer_matrix_multiply_top_defines.svh
// Assertion macros for the integer matrix multiply block.
// Taken in by the top level; relies on clk and rst_n being in scope.
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IMM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IMM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/imm_pkg.sv
// Shared types and constants for the integer matrix multiply block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package imm_pkg;

  localparam int IDX_W       = 5;   // row and column index ports
  localparam int CFG_W       = 6;   // configuration register width
  localparam int PROD_W      = 37;  // product word width
  localparam int QUEUE_DEPTH = 2;   // command queue entries, power of two

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_t;

  // Command handed from the front end to the back end.
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             err;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FLUSH,
    BK_DONE
  } back_state_t;

endpackage

>>> rtl/imm_queue.sv
// Small command queue between the front end and the back end.
// Depends on imm_pkg for its depth.
`timescale 1ns / 1ps

module imm_queue import imm_pkg::*; #(
  parameter int DATA_W = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty,
  output logic              full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/imm_front.sv
// Front end: configuration registers, input word decode and range checks.
// Depends on imm_pkg; feeds commands to imm_queue.
`timescale 1ns / 1ps

module imm_front import imm_pkg::*; #(
  parameter int MAX_DIM    = 32,
  parameter int ELEM_WIDTH = 16,
  parameter int DIM_W      = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            opcode,
  input  logic [IDX_W-1:0]      row_index,
  input  logic [IDX_W-1:0]      col_index,
  input  logic [ELEM_WIDTH-1:0] element_value,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  q_full,
  output logic                  busy,
  output logic                  push,
  output cmd_t                  push_cmd,
  output logic [ELEM_WIDTH-1:0] push_elem,
  output logic [DIM_W-1:0]      inner_eff
);

  logic [CFG_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0] rows_eff, cols_eff;
  logic             accept, row_ok_a, col_ok_a, row_ok_b, col_ok_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= CFG_W'(1);
      inner_dim_r <= CFG_W'(1);
      cols_b_r    <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROWS_A:    rows_a_r    <= cfg_wdata;
        CFG_INNER_DIM: inner_dim_r <= cfg_wdata;
        CFG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Register values above the storage size saturate to it.
  assign rows_eff  = (rows_a_r > MAX_DIM)    ? DIM_W'(MAX_DIM) : DIM_W'(rows_a_r);
  assign inner_eff = (inner_dim_r > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(inner_dim_r);
  assign cols_eff  = (cols_b_r > MAX_DIM)    ? DIM_W'(MAX_DIM) : DIM_W'(cols_b_r);

  assign accept   = start && !q_full;
  assign busy     = q_full;
  assign row_ok_a = (row_index < rows_eff);
  assign col_ok_a = (col_index < inner_eff);
  assign row_ok_b = (row_index < inner_eff);
  assign col_ok_b = (col_index < cols_eff);

  assign push_elem = element_value;

  // Out-of-range writes and the unused opcode are dropped here.
  always_comb begin
    push_cmd.op  = OP_COMPUTE;
    push_cmd.row = row_index;
    push_cmd.col = col_index;
    push_cmd.err = 1'b0;
    push         = 1'b0;
    case (op_t'(opcode))
      OP_WRITE_A: begin
        push_cmd.op = OP_WRITE_A;
        push        = accept && row_ok_a && col_ok_a;
      end
      OP_WRITE_B: begin
        push_cmd.op = OP_WRITE_B;
        push        = accept && row_ok_b && col_ok_b;
      end
      OP_COMPUTE: begin
        push_cmd.err = !(row_ok_a && col_ok_b);
        push         = accept;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/imm_back.sv
// Back end: element stores for A and B and the multiply-accumulate sequencer.
// Depends on imm_pkg; takes commands from imm_queue.
`timescale 1ns / 1ps

module imm_back import imm_pkg::*; #(
  parameter int MAX_DIM    = 32,
  parameter int ELEM_WIDTH = 16,
  parameter int DIM_W      = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  cmd_t                  head_cmd,
  input  logic [ELEM_WIDTH-1:0] head_elem,
  input  logic [DIM_W-1:0]      inner_eff,
  output logic                  pop,
  output logic                  res_valid,
  output logic [PROD_W-1:0]     res_value,
  output logic [IDX_W-1:0]      res_row,
  output logic [IDX_W-1:0]      res_col,
  output logic                  res_err
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

  back_state_t state_r, state_nxt;

  logic [IDX_W-1:0]               row_r, col_r;
  logic                           err_r;
  logic [LW-1:0]                  l_r;
  logic                           rd_v_r, mul_v_r;
  logic signed [ELEM_WIDTH-1:0]   a_q_r, b_q_r;
  logic signed [2*ELEM_WIDTH-1:0] prod_r;
  logic signed [PROD_W-1:0]       acc_r;

  logic              wr_a, wr_b, start_mac, last_step, run;
  logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;

  assign last_step = ((DIM_W'(l_r) + DIM_W'(1)) == inner_eff);
  assign wr_addr   = ADDR_W'(head_cmd.row * MAX_DIM + head_cmd.col);
  assign a_addr    = ADDR_W'(row_r * MAX_DIM + l_r);
  assign b_addr    = ADDR_W'(l_r * MAX_DIM + col_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && head_cmd.op == OP_COMPUTE) begin
          if (head_cmd.err || inner_eff == '0) begin
            state_nxt = BK_DONE;
          end else begin
            state_nxt = BK_RUN;
          end
        end
      end
      BK_RUN: begin
        if (last_step) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!rd_v_r && !mul_v_r) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE:  state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop       = 1'b0;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    start_mac = 1'b0;
    run       = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop       = !q_empty;
        wr_a      = !q_empty && head_cmd.op == OP_WRITE_A;
        wr_b      = !q_empty && head_cmd.op == OP_WRITE_B;
        start_mac = !q_empty && head_cmd.op == OP_COMPUTE;
      end
      BK_RUN:   run       = 1'b1;
      BK_FLUSH: ;
      BK_DONE:  res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= run;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= head_elem;
    end
    if (wr_b) begin
      mem_b[wr_addr] <= head_elem;
    end
    a_q_r <= mem_a[a_addr];
    b_q_r <= mem_b[b_addr];
  end

  always_ff @(posedge clk) begin
    prod_r <= a_q_r * b_q_r;
    if (start_mac) begin
      row_r <= head_cmd.row;
      col_r <= head_cmd.col;
      err_r <= head_cmd.err;
      l_r   <= '0;
      acc_r <= '0;
    end else begin
      if (run) begin
        l_r <= l_r + LW'(1);
      end
      if (mul_v_r) begin
        acc_r <= acc_r + PROD_W'(prod_r);
      end
    end
  end

  assign res_value = acc_r;
  assign res_row   = row_r;
  assign res_col   = col_r;
  assign res_err   = err_r;

endmodule

>>> rtl/integer_matrix_multiply_top.sv
// Top level of the integer matrix multiply block, C = A x B.
// Depends on imm_pkg, imm_front, imm_queue, imm_back and the assertion header.
`timescale 1ns / 1ps
`include "integer_matrix_multiply_top_defines.svh"

//  Channel   Handshake            Payload ports
//  -------   ------------------   ------------------------------------------------
//  input     start, busy          in_opcode, in_row_index, in_col_index,
//                                 in_element_value
//  result    out_valid (strobe)   out_product_value, out_row, out_col, out_index_error
//  config    cfg_we               cfg_index, cfg_wdata
//
// A word is taken when start is high and busy is low; busy rises only while the
// command queue between the front end and the back end is full. A write word
// is written to its store as it leaves the queue. A compute word runs the single
// multiply-accumulate loop that reads one element of A and one of B per cycle,
// then drains the read and multiply registers; an index error or an empty inner
// dimension goes from idle straight to the done state. Reset is synchronous and
// clears control state only; the element stores hold garbage until written.
// The result strobe lasts one cycle and the receiver cannot stall it.

module integer_matrix_multiply_top import imm_pkg::*; #(
  parameter int MAX_DIM    = 32,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [IDX_W-1:0]      in_row_index,
  input  logic [IDX_W-1:0]      in_col_index,
  input  logic [ELEM_WIDTH-1:0] in_element_value,
  // Result channel.
  output logic                  out_valid,
  output logic [PROD_W-1:0]     out_product_value,
  output logic [IDX_W-1:0]      out_row,
  output logic [IDX_W-1:0]      out_col,
  output logic                  out_index_error,
  // Configuration port.
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // Dimension values run from zero up to MAX_DIM.
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int QDATA_W = $bits(cmd_t) + ELEM_WIDTH;

  logic                  push, pop, q_empty, q_full;
  cmd_t                  push_cmd, head_cmd;
  logic [ELEM_WIDTH-1:0] push_elem, head_elem;
  logic [QDATA_W-1:0]    q_in, q_out;
  logic [DIM_W-1:0]      inner_eff;

  // The front end checks indexes against the configured sizes and drops
  // writes that fall outside them; a compute word outside them is queued with its error flag set.
  imm_front #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .DIM_W      (DIM_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .opcode        (in_opcode),
    .row_index     (in_row_index),
    .col_index     (in_col_index),
    .element_value (in_element_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .push_cmd      (push_cmd),
    .push_elem     (push_elem),
    .inner_eff     (inner_eff)
  );

  assign q_in = {push_cmd, push_elem};

  imm_queue #(
    .DATA_W (QDATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_in),
    .pop       (pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign {head_cmd, head_elem} = q_out;

  // The back end works through commands strictly in order, so a write that
  // follows a compute word never reaches the stores before that sum is done.
  imm_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .DIM_W      (DIM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_cmd  (head_cmd),
    .head_elem (head_elem),
    .inner_eff (inner_eff),
    .pop       (pop),
    .res_valid (out_valid),
    .res_value (out_product_value),
    .res_row   (out_row),
    .res_col   (out_col),
    .res_err   (out_index_error)
  );

  // An index error always comes back with a zero product.
  `IMM_ASSERT_IMP(a_err_zero, out_valid && out_index_error, out_product_value == '0, "error result carries a nonzero product")
  // Each result strobe is a single cycle; the sequencer returns to idle after it.
  `IMM_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe held for more than one cycle")
  // Queue bookkeeping: busy means the queue is full, so the queue cannot be empty while busy is high.
  `IMM_ASSERT_IMP(a_busy_not_empty, busy, !q_empty, "busy raised while the command queue is empty")

endmodule
